// ===== rtl/core/tlgp_pkg.sv =====
package tlgp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TIME_W    = 32;
   localparam int STANCE_W  = 24;
   localparam int DUTY_W    = FRAC_BITS;
   localparam int SEL_W     = 2;
   localparam int PER_W     = 32;
   localparam int SUM_W     = PER_W + 1;
   localparam int RAT_W     = FRAC_BITS + 1;
   localparam int PDVD_W    = STANCE_W + FRAC_BITS;
   localparam int PREM_W    = DUTY_W;
   localparam int MOD_STEPS = SUM_W + FRAC_BITS;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = STANCE_W;
   localparam int PCNT_W    = $clog2(PDVD_W + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_STANCE0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STANCE1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY0   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY1   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_SPHASE0 = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_SPHASE1 = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_INSTANC = CSR_IDX_W'(6);

   localparam logic [STANCE_W-1:0] STANCE_RST = STANCE_W'(150000);
   localparam logic [DUTY_W-1:0]   DUTY_RST   = DUTY_W'(32768);
   localparam logic [SEL_W-1:0]    INSTANC_RST = SEL_W'(2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_MUL
   } ctrl_state_type;

endpackage

// ===== rtl/core/two_leg_gait_phase_scheduler_core.sv =====
// channel | ports                                   | handshake
// req     | start, busy, req_now_us                 | taken when start && !busy
// rsp     | rsp_valid, rsp_leg{0,1}_{stance,phase}  | one-cycle strobe, no backpressure
// csr     | csr_valid, csr_ready, csr_index/wdata   | written when valid && ready
//
// One item per cycle while busy is low.
// The pipeline holds the 49-step restoring divider for the cycle phase plus
// the 16-step divider for the in-state phase, one bit per stage, plus the
// input, hand-off and output registers.
// After reset and after each csr write, busy is high while the period
// (40-step serial divider) and offsets are recomputed.
// The receiver cannot stall; the pipeline advances every cycle.
module two_leg_gait_phase_scheduler_core
   import tlgp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [TIME_W-1:0]    req_now_us,
   output logic                 rsp_valid,
   output logic                 rsp_leg0_stance,
   output logic [FRAC_BITS-1:0] rsp_leg0_phase,
   output logic                 rsp_leg1_stance,
   output logic [FRAC_BITS-1:0] rsp_leg1_phase,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int NS      = FRAC_BITS;
   localparam int LATENCY = MOD_STEPS + NS + 3;
   localparam logic [RAT_W-1:0] ONE_R = RAT_W'(1) << FRAC_BITS;

   logic [STANCE_W-1:0] stance_ff [2];
   logic [DUTY_W-1:0]   duty_ff   [2];
   logic [FRAC_BITS-1:0] sphase_ff [2];
   logic [SEL_W-1:0]    instanc_ff;
   logic                csr_fire;
   logic                req_fire;

   ctrl_state_type state_ff, state_in;
   logic p_load, p_run, p_mul;
   logic [PCNT_W-1:0] pcnt_ff;
   logic [PDVD_W-1:0] pdvd_ff [2];
   logic [PREM_W-1:0] prem_ff [2];
   logic [PDVD_W-1:0] pq_ff   [2];
   logic [PREM_W:0]   p_sh    [2];
   logic              p_ge    [2];
   logic [PER_W-1:0]  p_sat   [2];
   logic [PER_W+FRAC_BITS-1:0] p_prod [2];
   logic [PER_W-1:0]  period_ff [2];
   logic [PER_W-1:0]  offset_ff [2];
   logic [RAT_W-1:0]  ratio     [2];

   logic                 m_v_ff   [MOD_STEPS+1];
   logic                 m_v_in   [MOD_STEPS+1];
   logic [PER_W-1:0]     m_rem_ff [MOD_STEPS+1][2];
   logic [PER_W-1:0]     m_rem_in [MOD_STEPS+1][2];
   logic [SUM_W-1:0]     m_dvd_ff [MOD_STEPS+1][2];
   logic [SUM_W-1:0]     m_dvd_in [MOD_STEPS+1][2];
   logic [FRAC_BITS-1:0] m_q_ff   [MOD_STEPS+1][2];
   logic [FRAC_BITS-1:0] m_q_in   [MOD_STEPS+1][2];
   logic [SUM_W-1:0]     m_sh     [MOD_STEPS][2];
   logic                 m_ge     [MOD_STEPS][2];

   logic                 n_v_ff   [NS+1];
   logic                 n_v_in   [NS+1];
   logic [RAT_W-1:0]     n_rem_ff [NS+1][2];
   logic [RAT_W-1:0]     n_rem_in [NS+1][2];
   logic [RAT_W-1:0]     n_d_ff   [NS+1][2];
   logic [RAT_W-1:0]     n_d_in   [NS+1][2];
   logic [FRAC_BITS-1:0] n_q_ff   [NS+1][2];
   logic [FRAC_BITS-1:0] n_q_in   [NS+1][2];
   logic                 n_st_ff  [NS+1][2];
   logic                 n_st_in  [NS+1][2];
   logic [RAT_W:0]       n_sh     [NS][2];
   logic                 n_ge     [NS][2];
   logic [FRAC_BITS-1:0] f_val    [2];
   logic                 f_lt     [2];

   logic                 out_v_ff;
   logic                 out_st_ff [2];
   logic [FRAC_BITS-1:0] out_ph_ff [2];

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign busy      = (state_ff != ST_IDLE);
   assign req_fire  = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         stance_ff[0] <= STANCE_RST;
         stance_ff[1] <= STANCE_RST;
         duty_ff[0]   <= DUTY_RST;
         duty_ff[1]   <= DUTY_RST;
         sphase_ff[0] <= '0;
         sphase_ff[1] <= '0;
         instanc_ff   <= INSTANC_RST;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_STANCE0: stance_ff[0] <= csr_wdata[STANCE_W-1:0];
            CSR_STANCE1: stance_ff[1] <= csr_wdata[STANCE_W-1:0];
            CSR_DUTY0:   duty_ff[0]   <= csr_wdata[DUTY_W-1:0];
            CSR_DUTY1:   duty_ff[1]   <= csr_wdata[DUTY_W-1:0];
            CSR_SPHASE0: sphase_ff[0] <= csr_wdata[FRAC_BITS-1:0];
            CSR_SPHASE1: sphase_ff[1] <= csr_wdata[FRAC_BITS-1:0];
            CSR_INSTANC: instanc_ff   <= csr_wdata[SEL_W-1:0];
            default: ;
         endcase
      end
   end

   // recompute sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: state_in = ST_IDLE;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV:  state_in = (pcnt_ff == PCNT_W'(PDVD_W - 1)) ? ST_MUL : ST_DIV;
         ST_MUL:  state_in = ST_IDLE;
         default: state_in = ST_LOAD;
      endcase
      if (csr_fire) state_in = ST_LOAD;
   end

   always_comb begin
      p_load = 1'b0;
      p_run  = 1'b0;
      p_mul  = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_LOAD: p_load = 1'b1;
         ST_DIV:  p_run  = 1'b1;
         ST_MUL:  p_mul  = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         p_sh[l]  = {prem_ff[l], pdvd_ff[l][PDVD_W-1]};
         p_ge[l]  = (p_sh[l] >= {1'b0, duty_ff[l]});
         p_sat[l] = (|pq_ff[l][PDVD_W-1:PER_W]) ? '1 : pq_ff[l][PER_W-1:0];
         p_prod[l] = (PER_W+FRAC_BITS)'(sphase_ff[l]) * (PER_W+FRAC_BITS)'(p_sat[l]);
         ratio[l] = instanc_ff[l] ? {1'b0, duty_ff[l]} : ONE_R - {1'b0, duty_ff[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         pcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (p_run) pcnt_ff <= pcnt_ff + PCNT_W'(1);
         else       pcnt_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         if (p_load) begin
            pdvd_ff[l] <= {stance_ff[l], {FRAC_BITS{1'b0}}};
            prem_ff[l] <= '0;
            pq_ff[l]   <= '0;
         end else if (p_run) begin
            pdvd_ff[l] <= pdvd_ff[l] << 1;
            prem_ff[l] <= p_ge[l] ? PREM_W'(p_sh[l] - {1'b0, duty_ff[l]})
                                  : p_sh[l][PREM_W-1:0];
            pq_ff[l]   <= {pq_ff[l][PDVD_W-2:0], p_ge[l]};
         end
         if (p_mul) begin
            period_ff[l] <= p_sat[l];
            offset_ff[l] <= p_prod[l][PER_W+FRAC_BITS-1:FRAC_BITS];
         end
      end
   end

   // cycle phase: (now + offset) mod period, then 16 fraction bits
   always_comb begin
      m_v_in[0] = req_fire;
      for (int l = 0; l < 2; l++) begin
         m_rem_in[0][l] = '0;
         m_dvd_in[0][l] = {1'b0, req_now_us} + {1'b0, offset_ff[l]};
         m_q_in[0][l]   = '0;
      end
      for (int s = 0; s < MOD_STEPS; s++) begin
         m_v_in[s+1] = m_v_ff[s];
         for (int l = 0; l < 2; l++) begin
            m_sh[s][l] = {m_rem_ff[s][l], m_dvd_ff[s][l][SUM_W-1]};
            m_ge[s][l] = (m_sh[s][l] >= {1'b0, period_ff[l]});
            m_rem_in[s+1][l] = m_ge[s][l] ? PER_W'(m_sh[s][l] - {1'b0, period_ff[l]})
                                          : m_sh[s][l][PER_W-1:0];
            m_dvd_in[s+1][l] = m_dvd_ff[s][l] << 1;
            m_q_in[s+1][l]   = {m_q_ff[s][l][FRAC_BITS-2:0], m_ge[s][l]};
         end
      end
   end

   // phase within state
   always_comb begin
      n_v_in[0] = m_v_ff[MOD_STEPS];
      for (int l = 0; l < 2; l++) begin
         f_val[l] = (period_ff[l] == '0) ? '0 : m_q_ff[MOD_STEPS][l];
         f_lt[l]  = ({1'b0, f_val[l]} < ratio[l]);
         n_st_in[0][l] = f_lt[l] ? instanc_ff[l] : !instanc_ff[l];
         n_rem_in[0][l] = f_lt[l] ? {1'b0, f_val[l]} : {1'b0, f_val[l]} - ratio[l];
         n_d_in[0][l]   = f_lt[l] ? ratio[l] : ONE_R - ratio[l];
         n_q_in[0][l]   = '0;
      end
      for (int s = 0; s < NS; s++) begin
         n_v_in[s+1] = n_v_ff[s];
         for (int l = 0; l < 2; l++) begin
            n_sh[s][l] = {n_rem_ff[s][l], 1'b0};
            n_ge[s][l] = (n_sh[s][l] >= {1'b0, n_d_ff[s][l]});
            n_rem_in[s+1][l] = n_ge[s][l] ? RAT_W'(n_sh[s][l] - {1'b0, n_d_ff[s][l]})
                                          : n_sh[s][l][RAT_W-1:0];
            n_d_in[s+1][l]  = n_d_ff[s][l];
            n_q_in[s+1][l]  = {n_q_ff[s][l][FRAC_BITS-2:0], n_ge[s][l]};
            n_st_in[s+1][l] = n_st_ff[s][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= MOD_STEPS; s++) m_v_ff[s] <= 1'b0;
         for (int s = 0; s <= NS; s++) n_v_ff[s] <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         for (int s = 0; s <= MOD_STEPS; s++) m_v_ff[s] <= m_v_in[s];
         for (int s = 0; s <= NS; s++) n_v_ff[s] <= n_v_in[s];
         out_v_ff <= n_v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= MOD_STEPS; s++) begin
         for (int l = 0; l < 2; l++) begin
            m_rem_ff[s][l] <= m_rem_in[s][l];
            m_dvd_ff[s][l] <= m_dvd_in[s][l];
            m_q_ff[s][l]   <= m_q_in[s][l];
         end
      end
      for (int s = 0; s <= NS; s++) begin
         for (int l = 0; l < 2; l++) begin
            n_rem_ff[s][l] <= n_rem_in[s][l];
            n_d_ff[s][l]   <= n_d_in[s][l];
            n_q_ff[s][l]   <= n_q_in[s][l];
            n_st_ff[s][l]  <= n_st_in[s][l];
         end
      end
      for (int l = 0; l < 2; l++) begin
         out_st_ff[l] <= n_st_ff[NS][l];
         out_ph_ff[l] <= n_q_ff[NS][l];
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_leg0_stance = out_st_ff[0];
   assign rsp_leg0_phase  = out_ph_ff[0];
   assign rsp_leg1_stance = out_st_ff[1];
   assign rsp_leg1_phase  = out_ph_ff[1];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ##LATENCY rsp_valid)
      else $error("item result missing at pipeline exit");

   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> busy)
      else $error("csr write did not start recompute");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !m_v_in[0])
      else $error("item taken during period recompute");

endmodule
